// ===== hdl/spef_pkg.sv =====
// Shared types and constants of the SPI packet exchange framer.
`default_nettype none

package spef_pkg;

  // Request codes carried in the input item's req_type field
  localparam logic [1:0] REQ_SPI_WORD = 2'd0;
  localparam logic [1:0] REQ_APPEND   = 2'd1;
  localparam logic [1:0] REQ_SEND     = 2'd2;
  localparam logic [1:0] REQ_READY    = 2'd3;

  // Result kinds carried in the result item's kind field
  localparam logic [1:0] KIND_STATUS  = 2'd0;
  localparam logic [1:0] KIND_TX_WORD = 2'd1;
  localparam logic [1:0] KIND_RX_HDR  = 2'd2;
  localparam logic [1:0] KIND_RX_DATA = 2'd3;

  // Most bytes one append request carries
  localparam logic [2:0] APPEND_MAX = 3'd4;

  // Entries of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] rx_word;
    logic [31:0] append_bytes;
    logic [2:0]  append_count;
    logic [7:0]  send_command;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] word;
    logic [7:0]  rx_command;
    logic [7:0]  rx_length;
    logic        last;
    logic        busy_res;
  } out_t;

  typedef enum logic [1:0] {
    OP_SPI,
    OP_APPEND,
    OP_SEND,
    OP_READY
  } op_t;

  // Classified request as it travels from front to back
  typedef struct packed {
    op_t         op;
    logic [31:0] data;
    logic [2:0]  cnt;
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_EXEC,
    B_APPEND,
    B_TX_OUT,
    B_RX_CHK,
    B_DL_RD,
    B_DL_CAP,
    B_EMIT
  } back_state_t;

endpackage

`default_nettype wire

// ===== hdl/spef_front.sv =====
// Front end: accepts input transfers and classifies them into commands.
`default_nettype none

module spef_front
  import spef_pkg::*;
(
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      push,
  output cmd_t      push_cmd,
  input  wire logic q_full
);

  // Hold off the sender while the queue has no room
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // Reduce each request to an op and the payload it needs
  always_comb begin
    push_cmd.op   = OP_READY;
    push_cmd.data = '0;
    push_cmd.cnt  = '0;
    case (in_data.req_type)
      REQ_SPI_WORD: begin
        push_cmd.op   = OP_SPI;
        push_cmd.data = {16'd0, in_data.rx_word};
      end
      REQ_APPEND: begin
        push_cmd.op   = OP_APPEND;
        push_cmd.data = in_data.append_bytes;
        // clamp oversized counts to a full word
        push_cmd.cnt  = (in_data.append_count > APPEND_MAX) ? APPEND_MAX
                                                            : in_data.append_count;
      end
      REQ_SEND: begin
        push_cmd.op   = OP_SEND;
        push_cmd.data = {24'd0, in_data.send_command};
      end
      default: begin
        push_cmd.op = OP_READY;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/spef_queue.sv =====
// Short command queue between the front end and the back end.
`default_nettype none

module spef_queue
  import spef_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output cmd_t      head,
  output logic      empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/spef_back.sv =====
// Back end: packet stores, transmit/receive sequencer and result register.
`default_nettype none

module spef_back
  import spef_pkg::*;
#(
  parameter int PACKET_BYTES = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cmd_t q_head,
  input  wire logic q_empty,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  localparam int LEN_W  = $clog2(PACKET_BYTES + 2);
  localparam int HALVES = (PACKET_BYTES + 1) / 2;
  localparam int ADDR_W = (HALVES > 1) ? $clog2(HALVES) : 1;
  localparam logic [LEN_W-1:0] CAP = LEN_W'(PACKET_BYTES);

  function automatic logic [ADDR_W-1:0] half_addr(input logic [LEN_W-1:0] idx);
    return ADDR_W'(idx >> 1);
  endfunction

  back_state_t      state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  out_t             res_r, res_nxt;
  out_t             out_data_r, out_data_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             receiving_r, receiving_nxt;
  logic             header_seen_r, header_seen_nxt;
  logic [7:0]       rx_cmd_r, rx_cmd_nxt;
  logic [LEN_W-1:0] rx_len_r, rx_len_nxt;
  logic [LEN_W-1:0] rx_fill_r, rx_fill_nxt;
  logic [LEN_W-1:0] tx_len_r, tx_len_nxt;
  logic [LEN_W-1:0] tx_next_r, tx_next_nxt;
  logic [LEN_W-1:0] rd_idx_r, rd_idx_nxt;

  // Byte stores split into even and odd banks, one halfword per address
  logic [7:0]        tx_lo_mem [HALVES];
  logic [7:0]        tx_hi_mem [HALVES];
  logic [HALVES-1:0] tx_lo_vld_r;
  logic [HALVES-1:0] tx_hi_vld_r;
  logic [7:0]        rx_lo_mem [HALVES];
  logic [7:0]        rx_hi_mem [HALVES];
  logic [7:0]        tx_lo_rd_r, tx_hi_rd_r;
  logic              tx_lo_ok_r, tx_hi_ok_r;
  logic [7:0]        rx_lo_rd_r, rx_hi_rd_r;

  logic              tx_we, tx_wr_hi, tx_re, rx_we, rx_re, out_load;
  logic [ADDR_W-1:0] tx_waddr, tx_raddr, rx_waddr, rx_raddr;
  logic              slot_free, busy, tx_more, rx_room, rx_done, app_go;
  logic [LEN_W:0]    rd_idx_p2;
  logic [LEN_W-1:0]  rd_idx_p1;

  assign slot_free = !out_valid_r || !out_stall;
  assign busy      = (tx_len_r != '0) || receiving_r;
  assign tx_more   = tx_next_r < tx_len_r;
  assign rx_room   = rx_fill_r < rx_len_r;
  assign rx_done   = !rx_room;
  assign app_go    = (cmd_r.cnt != '0) && (tx_len_r < CAP);
  assign rd_idx_p2 = {1'b0, rd_idx_r} + (LEN_W + 1)'(2);
  assign rd_idx_p1 = rd_idx_r + 1'b1;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          state_nxt = B_EXEC;
        end
      end
      B_EXEC: begin
        case (cmd_r.op)
          OP_SPI: begin
            if (receiving_r) begin
              state_nxt = B_RX_CHK;
            end else if (tx_more) begin
              state_nxt = B_TX_OUT;
            end else begin
              state_nxt = B_EMIT;
            end
          end
          OP_APPEND: state_nxt = B_APPEND;
          default:   state_nxt = B_EMIT;
        endcase
      end
      B_APPEND: state_nxt = app_go ? B_APPEND : B_EMIT;
      B_TX_OUT: state_nxt = B_EMIT;
      B_RX_CHK: state_nxt = B_EMIT;
      B_DL_RD:  state_nxt = B_DL_CAP;
      B_DL_CAP: state_nxt = B_EMIT;
      B_EMIT: begin
        if (slot_free) begin
          state_nxt = res_r.last ? B_IDLE : B_DL_RD;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // Datapath and store control
  always_comb begin
    cmd_nxt         = cmd_r;
    res_nxt         = res_r;
    receiving_nxt   = receiving_r;
    header_seen_nxt = header_seen_r;
    rx_cmd_nxt      = rx_cmd_r;
    rx_len_nxt      = rx_len_r;
    rx_fill_nxt     = rx_fill_r;
    tx_len_nxt      = tx_len_r;
    tx_next_nxt     = tx_next_r;
    rd_idx_nxt      = rd_idx_r;
    pop             = 1'b0;
    tx_we           = 1'b0;
    tx_wr_hi        = tx_len_r[0];
    tx_waddr        = half_addr(tx_len_r);
    tx_re           = 1'b0;
    tx_raddr        = half_addr(tx_next_r);
    rx_we           = 1'b0;
    rx_waddr        = half_addr(rx_fill_r);
    rx_re           = 1'b0;
    rx_raddr        = half_addr(rd_idx_r);
    out_load        = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          pop     = 1'b1;
          cmd_nxt = q_head;
        end
      end
      B_EXEC: begin
        case (cmd_r.op)
          OP_SPI: begin
            if (receiving_r) begin
              if (header_seen_r) begin
                if (rx_room) begin
                  rx_we       = 1'b1;
                  rx_fill_nxt = rx_fill_r + LEN_W'(2);
                end
              end else begin
                header_seen_nxt = 1'b1;
                rx_cmd_nxt      = cmd_r.data[15:8];
                rx_len_nxt      = (cmd_r.data[7:0] > 8'(PACKET_BYTES)) ? CAP
                                                                       : LEN_W'(cmd_r.data[7:0]);
              end
            end else if (tx_more) begin
              tx_re       = 1'b1;
              tx_next_nxt = tx_next_r + LEN_W'(2);
            end else begin
              // transmit finished: turn around to receive
              tx_len_nxt      = '0;
              receiving_nxt   = 1'b1;
              header_seen_nxt = 1'b0;
              rx_cmd_nxt      = '0;
              rx_len_nxt      = '0;
              rx_fill_nxt     = '0;
              res_nxt         = '{KIND_STATUS, 16'd0, 8'd0, 8'd0, 1'b1, 1'b0};
            end
          end
          OP_SEND: begin
            receiving_nxt = 1'b0;
            tx_next_nxt   = '0;
            res_nxt = '{KIND_TX_WORD, {cmd_r.data[7:0], 8'(tx_len_r)}, 8'd0, 8'd0,
                        1'b1, 1'b0};
          end
          OP_READY: begin
            res_nxt = '{KIND_TX_WORD, 16'd0, 8'd0, 8'd0, 1'b1, 1'b0};
          end
          default: begin
          end
        endcase
      end
      B_APPEND: begin
        if (app_go) begin
          tx_we          = 1'b1;
          tx_len_nxt     = tx_len_r + 1'b1;
          cmd_nxt.data   = cmd_r.data >> 8;
          cmd_nxt.cnt    = cmd_r.cnt - 1'b1;
        end else begin
          res_nxt = '{KIND_STATUS, 16'd0, 8'd0, 8'd0, 1'b1, 1'b0};
        end
      end
      B_TX_OUT: begin
        res_nxt = '{KIND_TX_WORD,
                    {tx_hi_ok_r ? tx_hi_rd_r : 8'd0, tx_lo_ok_r ? tx_lo_rd_r : 8'd0},
                    8'd0, 8'd0, 1'b1, 1'b0};
      end
      B_RX_CHK: begin
        if (rx_done) begin
          receiving_nxt = 1'b0;
          rd_idx_nxt    = '0;
          res_nxt = '{KIND_RX_HDR, 16'd0, rx_cmd_r, 8'(rx_len_r), rx_len_r == '0, 1'b0};
        end else begin
          res_nxt = '{KIND_TX_WORD, 16'd0, 8'd0, 8'd0, 1'b1, 1'b0};
        end
      end
      B_DL_RD: begin
        rx_re = 1'b1;
      end
      B_DL_CAP: begin
        // drop the pad byte past an odd length
        res_nxt = '{KIND_RX_DATA,
                    {(rd_idx_p1 < rx_len_r) ? rx_hi_rd_r : 8'd0, rx_lo_rd_r},
                    rx_cmd_r, 8'(rx_len_r),
                    rd_idx_p2 >= {1'b0, rx_len_r}, 1'b0};
        rd_idx_nxt = rd_idx_r + LEN_W'(2);
      end
      B_EMIT: begin
        out_load = slot_free;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_data_nxt          = res_r;
    out_data_nxt.busy_res = busy;
    out_valid_nxt         = out_load ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= B_IDLE;
      out_valid_r   <= 1'b0;
      receiving_r   <= 1'b0;
      header_seen_r <= 1'b0;
      rx_cmd_r      <= '0;
      rx_len_r      <= '0;
      rx_fill_r     <= '0;
      tx_len_r      <= '0;
      tx_next_r     <= '0;
      rd_idx_r      <= '0;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      receiving_r   <= receiving_nxt;
      header_seen_r <= header_seen_nxt;
      rx_cmd_r      <= rx_cmd_nxt;
      rx_len_r      <= rx_len_nxt;
      rx_fill_r     <= rx_fill_nxt;
      tx_len_r      <= tx_len_nxt;
      tx_next_r     <= tx_next_nxt;
      rd_idx_r      <= rd_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    res_r <= res_nxt;
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Transmit store valid bits: unwritten bytes read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_lo_vld_r <= '0;
      tx_hi_vld_r <= '0;
    end else if (tx_we) begin
      if (tx_wr_hi) begin
        tx_hi_vld_r[tx_waddr] <= 1'b1;
      end else begin
        tx_lo_vld_r[tx_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tx_we && !tx_wr_hi) begin
      tx_lo_mem[tx_waddr] <= cmd_r.data[7:0];
    end
    if (tx_we && tx_wr_hi) begin
      tx_hi_mem[tx_waddr] <= cmd_r.data[7:0];
    end
    if (tx_re) begin
      tx_lo_rd_r <= tx_lo_mem[tx_raddr];
      tx_hi_rd_r <= tx_hi_mem[tx_raddr];
      tx_lo_ok_r <= tx_lo_vld_r[tx_raddr];
      tx_hi_ok_r <= tx_hi_vld_r[tx_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_lo_mem[rx_waddr] <= cmd_r.data[7:0];
      rx_hi_mem[rx_waddr] <= cmd_r.data[15:8];
    end
    if (rx_re) begin
      rx_lo_rd_r <= rx_lo_mem[rx_raddr];
      rx_hi_rd_r <= rx_hi_mem[rx_raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/spi_packet_exchange_framer_core.sv =====
// Top level of the half-duplex SPI packet exchange framer.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------
//   in_     | input     | in_valid/in_stall  | in_t: request, SPI word, bytes
//   out_    | output    | out_valid/out_stall| out_t: kind, word, rx header
//
// A transfer takes place on a rising edge with valid high and stall low.
// Sequencing: the back-end sequencer handles one command at a time, and packet
// delivery passes each halfword after the header through the registered read
// of the receive store before it is emitted.
// Reset (rst_n low, synchronous) clears the sequencer, lengths, pointers and
// the transmit store's valid bits; the receive store keeps its contents.
// Stalls: a two-entry command queue lets the front keep taking transfers
// while the back waits on out_stall; results sit in one output register.
`default_nettype none

module spi_packet_exchange_framer_core
  import spef_pkg::*;
#(
  parameter int PACKET_BYTES = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  logic push, pop, q_full, q_empty;
  cmd_t push_cmd, q_head;

  // Classify incoming transfers into commands
  spef_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full)
  );

  // Decouple front from back
  spef_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  // Carry out commands against the packet stores and emit results
  spef_back #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
